[design/frtc_pkg.sv]
// Shared constants, types and status codes of the free range table.
package frtc_pkg;

  localparam int ADDR_BITS  = 16;
  localparam int MAX_RANGES = 16;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int LEN_W      = ADDR_BITS + 1;
  localparam int SUM_W      = ADDR_BITS + 2;

  localparam logic [LEN_W-1:0] SPACE_SIZE = {1'b1, {ADDR_BITS{1'b0}}};

  typedef logic [1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOT_FREE = 2'd1;
  localparam status_t ST_OVERLAP  = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_W-1:0]     length;
  } range_t;

  typedef struct packed {
    logic [SUM_W-1:0] ent_end;
    logic [SUM_W-1:0] req_end;
    logic             st_le_s;
    logic             st_lt_s;
    logic             fits;
    logic             at_front;
    logic             at_back;
    logic             end_gt_s;
    logic             end_eq_s;
    logic             st_lt_rend;
    logic             st_eq_rend;
  } rng_cmp_t;

endpackage

[design/frtc_ifs.sv]
// Request and result channel interfaces of the free range table.
interface frtc_req_if import frtc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [ADDR_BITS-1:0] span_start;
  logic [LEN_W-1:0]     span_length;

  modport source (output valid, kind, span_start, span_length, input ready);
  modport sink   (input valid, kind, span_start, span_length, output ready);
endinterface

interface frtc_res_if import frtc_pkg::*;;
  logic             valid;
  logic             ready;
  status_t          status;
  logic [CNT_W-1:0] range_count;

  modport source (output valid, status, range_count, input ready);
  modport sink   (input valid, status, range_count, output ready);
endinterface

[design/frtc_range_unit.sv]
// Shared compare unit: relates one table entry to the current request span.
module frtc_range_unit import frtc_pkg::*; (
  input  range_t               ent,
  input  logic [ADDR_BITS-1:0] s,
  input  logic [LEN_W-1:0]     len,
  output rng_cmp_t             cmp
);

  logic [SUM_W-1:0] s_x;
  logic [SUM_W-1:0] st_x;

  assign s_x  = SUM_W'(s);
  assign st_x = SUM_W'(ent.start);

  always_comb begin
    cmp.ent_end    = st_x + SUM_W'(ent.length);
    cmp.req_end    = s_x + SUM_W'(len);
    cmp.st_le_s    = (ent.start <= s);
    cmp.st_lt_s    = (ent.start < s);
    cmp.fits       = (cmp.req_end <= cmp.ent_end);
    cmp.at_front   = (ent.start == s);
    cmp.at_back    = (cmp.req_end == cmp.ent_end);
    cmp.end_gt_s   = (cmp.ent_end > s_x);
    cmp.end_eq_s   = (cmp.ent_end == s_x);
    cmp.st_lt_rend = (st_x < cmp.req_end);
    cmp.st_eq_rend = (st_x == cmp.req_end);
  end

endmodule

[design/free_range_table_coalescing.sv]
// Top level of the free range table: sequencer, range memory and result register.
// The scan reads and compares one table entry per cycle; after it a delete moves
//   the later entries down one slot, an insert moves them up one slot.
// req.ready is high only in idle; one request is handled at a time.
// Reset (and every total_size write) loads entry 0 with [0, size).
module free_range_table_coalescing import frtc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  frtc_req_if.sink         req,
  frtc_res_if.source       res,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  // Sequencer state codes
  localparam logic [3:0] S_INIT  = 4'd0;  // load entry 0 from total_size
  localparam logic [3:0] S_IDLE  = 4'd1;  // wait for a request
  localparam logic [3:0] S_START = 4'd2;  // screen special cases, issue read of entry 0
  localparam logic [3:0] S_SCAN  = 4'd3;  // compare one entry per cycle
  localparam logic [3:0] S_FDEC  = 4'd4;  // free: decide merge, insert or reject
  localparam logic [3:0] S_RM    = 4'd5;  // delete: move entries down one slot
  localparam logic [3:0] S_PRE   = 4'd6;  // insert: prime read of the last entry
  localparam logic [3:0] S_INS   = 4'd7;  // insert: move entries up, then place new one
  localparam logic [3:0] S_FIN   = 4'd8;  // hand the result to the output register

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [LEN_W-1:0] total_size;
  logic [LEN_W-1:0] size_clamped;

  // Latched request
  logic                 kind_r;
  logic [ADDR_BITS-1:0] s_r;
  logic [LEN_W-1:0]     len_r;

  // Working registers
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] cur, cur_next;
  logic [IDX_W-1:0] ins_pos, ins_pos_next;
  logic [CNT_W-1:0] pos, pos_next;
  range_t           ins_ent, ins_ent_next;
  range_t           prev_ent, prev_ent_next;
  range_t           next_ent, next_ent_next;
  logic             prev_valid, prev_valid_next;
  logic             next_valid, next_valid_next;
  logic             next_ovl, next_ovl_next;
  logic             next_join, next_join_next;
  status_t          status_r, status_next;

  // Result register
  logic             res_valid;
  status_t          res_status;
  logic [CNT_W-1:0] res_count;
  logic             res_load;

  // Range memory: one write and one registered read per cycle
  range_t           mem [MAX_RANGES];
  range_t           rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  range_t           mem_wdata;
  logic [IDX_W-1:0] rd_addr;

  // Shared compare unit, fed by the memory read data or by the held predecessor
  range_t   unit_ent;
  rng_cmp_t ucmp;

  logic [CNT_W-1:0] idx_p1;
  logic [CNT_W-1:0] cur_p1;
  logic [CNT_W-1:0] pos_p1;
  logic [CNT_W-1:0] pos_m1;
  logic             last;
  logic             join_p;
  logic             join_n;
  logic             ovl;

  assign size_clamped = (total_size > SPACE_SIZE) ? SPACE_SIZE : total_size;

  assign unit_ent = (state == S_FDEC) ? prev_ent : rdata;

  frtc_range_unit u_range_unit (
    .ent (unit_ent),
    .s   (s_r),
    .len (len_r),
    .cmp (ucmp)
  );

  assign idx_p1 = {1'b0, idx} + CNT_W'(1);
  assign cur_p1 = {1'b0, cur} + CNT_W'(1);
  assign pos_p1 = pos + CNT_W'(1);
  assign pos_m1 = pos - CNT_W'(1);
  assign last   = (idx_p1 >= count);

  // Free merge decisions; the predecessor goes through the compare unit in S_FDEC
  assign ovl    = (prev_valid && ucmp.end_gt_s) || (next_valid && next_ovl);
  assign join_p = prev_valid && ucmp.end_eq_s;
  assign join_n = next_valid && next_join;

  assign req.ready   = (state == S_IDLE);
  assign res.valid   = res_valid;
  assign res.status  = res_status;
  assign res.range_count = res_count;

  assign res_load = (state == S_FIN) && (!res_valid || res.ready);

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    cur_next        = cur;
    ins_pos_next    = ins_pos;
    pos_next        = pos;
    ins_ent_next    = ins_ent;
    prev_ent_next   = prev_ent;
    next_ent_next   = next_ent;
    prev_valid_next = prev_valid;
    next_valid_next = next_valid;
    next_ovl_next   = next_ovl;
    next_join_next  = next_join;
    status_next     = status_r;
    mem_we          = 1'b0;
    mem_waddr       = idx;
    mem_wdata       = rdata;
    rd_addr         = '0;

    case (state)
      S_INIT: begin
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = '{start: '0, length: size_clamped};
        count_next = (size_clamped != '0) ? CNT_W'(1) : '0;
        state_next = S_IDLE;
      end

      S_IDLE: begin
        if (req.valid) begin
          state_next = S_START;
        end
      end

      S_START: begin
        prev_valid_next = 1'b0;
        next_valid_next = 1'b0;
        idx_next        = '0;
        status_next     = ST_OK;
        pos_next        = count;
        if (len_r == '0) begin
          // zero-length span: nothing changes
          state_next = S_FIN;
        end else if (kind_r == KIND_ALLOC) begin
          if (count == '0) begin
            status_next = ST_NOT_FREE;
            state_next  = S_FIN;
          end else begin
            state_next = S_SCAN;
          end
        end else begin
          if (ucmp.req_end > SUM_W'(SPACE_SIZE)) begin
            // span runs past the end of the address space
            status_next = ST_OVERLAP;
            state_next  = S_FIN;
          end else if (count == '0) begin
            mem_we     = 1'b1;
            mem_waddr  = '0;
            mem_wdata  = '{start: s_r, length: len_r};
            count_next = CNT_W'(1);
            state_next = S_FIN;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        rd_addr = idx_p1[IDX_W-1:0];
        if (kind_r == KIND_ALLOC) begin
          if (ucmp.st_le_s && ucmp.fits) begin
            if (ucmp.at_front && ucmp.at_back) begin
              cur_next   = idx;
              state_next = S_RM;
            end else if (ucmp.at_front) begin
              mem_we     = 1'b1;
              mem_waddr  = idx;
              mem_wdata  = '{start: ucmp.req_end[ADDR_BITS-1:0],
                             length: rdata.length - len_r};
              state_next = S_FIN;
            end else if (ucmp.at_back) begin
              mem_we     = 1'b1;
              mem_waddr  = idx;
              mem_wdata  = '{start: rdata.start, length: rdata.length - len_r};
              state_next = S_FIN;
            end else if (count >= CNT_W'(MAX_RANGES)) begin
              status_next = ST_FULL;
              state_next  = S_FIN;
            end else begin
              // split: trim this entry, then insert the tail after it
              mem_we       = 1'b1;
              mem_waddr    = idx;
              mem_wdata    = '{start: rdata.start, length: LEN_W'(s_r - rdata.start)};
              ins_ent_next = '{start: ucmp.req_end[ADDR_BITS-1:0],
                               length: LEN_W'(ucmp.ent_end - ucmp.req_end)};
              ins_pos_next = idx + IDX_W'(1);
              cur_next     = count[IDX_W-1:0];
              state_next   = S_PRE;
            end
          end else if (last) begin
            status_next = ST_NOT_FREE;
            state_next  = S_FIN;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end else begin
          if (!ucmp.st_lt_s) begin
            // first entry at or after the span is the successor
            pos_next        = {1'b0, idx};
            next_ent_next   = rdata;
            next_valid_next = 1'b1;
            next_ovl_next   = ucmp.st_lt_rend;
            next_join_next  = ucmp.st_eq_rend;
            state_next      = S_FDEC;
          end else begin
            prev_ent_next   = rdata;
            prev_valid_next = 1'b1;
            if (last) begin
              pos_next   = count;
              state_next = S_FDEC;
            end else begin
              idx_next = idx + IDX_W'(1);
            end
          end
        end
      end

      S_FDEC: begin
        rd_addr = pos_p1[IDX_W-1:0];
        if (ovl) begin
          status_next = ST_OVERLAP;
          state_next  = S_FIN;
        end else if (join_p && join_n) begin
          // bridge both neighbors, then drop the successor
          mem_we     = 1'b1;
          mem_waddr  = pos_m1[IDX_W-1:0];
          mem_wdata  = '{start: prev_ent.start,
                         length: prev_ent.length + len_r + next_ent.length};
          cur_next   = pos[IDX_W-1:0];
          state_next = S_RM;
        end else if (join_n) begin
          mem_we     = 1'b1;
          mem_waddr  = pos[IDX_W-1:0];
          mem_wdata  = '{start: s_r, length: next_ent.length + len_r};
          state_next = S_FIN;
        end else if (join_p) begin
          mem_we     = 1'b1;
          mem_waddr  = pos_m1[IDX_W-1:0];
          mem_wdata  = '{start: prev_ent.start, length: prev_ent.length + len_r};
          state_next = S_FIN;
        end else if (count >= CNT_W'(MAX_RANGES)) begin
          status_next = ST_FULL;
          state_next  = S_FIN;
        end else begin
          ins_ent_next = '{start: s_r, length: len_r};
          ins_pos_next = pos[IDX_W-1:0];
          cur_next     = count[IDX_W-1:0];
          state_next   = S_PRE;
        end
      end

      S_RM: begin
        // rdata holds entry cur+1; move it down and fetch the next one
        rd_addr = cur + IDX_W'(2);
        if (cur_p1 < count) begin
          mem_we    = 1'b1;
          mem_waddr = cur;
          mem_wdata = rdata;
          cur_next  = cur + IDX_W'(1);
        end else begin
          count_next = count - CNT_W'(1);
          state_next = S_FIN;
        end
      end

      S_PRE: begin
        rd_addr    = cur - IDX_W'(1);
        state_next = S_INS;
      end

      S_INS: begin
        // rdata holds entry cur-1; move it up until the gap reaches ins_pos
        rd_addr = cur - IDX_W'(2);
        if (cur != ins_pos) begin
          mem_we    = 1'b1;
          mem_waddr = cur;
          mem_wdata = rdata;
          cur_next  = cur - IDX_W'(1);
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = ins_pos;
          mem_wdata  = ins_ent;
          count_next = count + CNT_W'(1);
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        if (!res_valid || res.ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      count      <= '0;
      total_size <= SPACE_SIZE;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        // reload the table from the new size
        total_size <= cfg_wdata;
        state      <= S_INIT;
      end else begin
        state <= state_next;
      end
      count <= count_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      kind_r <= req.kind;
      s_r    <= req.span_start;
      len_r  <= req.span_length;
    end
    idx        <= idx_next;
    cur        <= cur_next;
    ins_pos    <= ins_pos_next;
    pos        <= pos_next;
    ins_ent    <= ins_ent_next;
    prev_ent   <= prev_ent_next;
    next_ent   <= next_ent_next;
    prev_valid <= prev_valid_next;
    next_valid <= next_valid_next;
    next_ovl   <= next_ovl_next;
    next_join  <= next_join_next;
    status_r   <= status_next;
    if (res_load) begin
      res_status <= status_r;
      res_count  <= count;
    end
  end

  // Range memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[rd_addr];
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RANGES))
    else $error("range count above table depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == ST_FULL) |-> res.range_count == CNT_W'(MAX_RANGES))
    else $error("table full reported with free slots");

  a_ins_cursor: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS) |-> cur >= ins_pos)
    else $error("insert cursor passed insert position");

  a_rm_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_RM) |-> count != '0)
    else $error("delete from empty table");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && !cfg_we) |=> state == S_START)
    else $error("accepted request did not start");

endmodule
